@@ src/periodic_due_time_scheduler_macros.svh @@
// Assertion macros for the periodic due-time scheduler.
// Needs a clock named clk and an active-low reset named arst_n in the scope of use.
`ifndef PERIODIC_DUE_TIME_SCHEDULER_MACROS_SVH
`define PERIODIC_DUE_TIME_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PDTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/pdts_pkg.sv @@
// Shared constants, types and state encoding of the periodic due-time scheduler.
// No dependencies; every other file of the block but the assertion macro header imports this package.
`timescale 1ns / 1ps

package pdts_pkg;

	localparam int NUM_CHANNELS = 5;
	localparam int REG_COUNT    = 5;

	localparam int NOW_W     = 32;
	localparam int PERIOD_W  = 31;
	localparam int MASK_W    = REG_COUNT;
	localparam int CFG_IDX_W = $clog2(REG_COUNT);
	localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int DCNT_W    = $clog2(PERIOD_W);

	localparam logic [PERIOD_W-1:0] PERIOD_RST [REG_COUNT] = '{
		31'd5000, 31'd10000, 31'd50000, 31'd250000, 31'd5000000
	};

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DIV,
		ST_UPD,
		ST_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic            capture;
		logic            load_due;
		logic            step_due;
		logic            div_start;
		logic            div_step;
		logic            div_commit;
		logic            push;
		logic [CH_W-1:0] ch;
	} dp_cmd_t;

	typedef struct packed {
		logic is_start;
		logic fire;
		logic fast;
		logic div_last;
		logic slot_free;
	} dp_status_t;

endpackage

@@ src/pdts_ifs.sv @@
// Valid/ready channel interfaces for request and response words.
// Depends on pdts_pkg for the field widths.
`timescale 1ns / 1ps

interface pdts_req_if;
	import pdts_pkg::*;

	logic             valid;
	logic             ready;
	logic             req_type;
	logic [NOW_W-1:0] now_us;

	modport source (output valid, output req_type, output now_us, input ready);
	modport sink   (input valid, input req_type, input now_us, output ready);
endinterface

interface pdts_rsp_if;
	import pdts_pkg::*;

	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] fire_mask;

	modport source (output valid, output fire_mask, input ready);
	modport sink   (input valid, input fire_mask, output ready);
endinterface

@@ src/periodic_due_time_scheduler.sv @@
// Channel   Dir  Payload                         Handshake
// req       in   req_type (1), now_us (32)       valid/ready
// rsp       out  fire_mask (5)                   valid/ready
// cfg       in   cfg_index (3), cfg_data (31)    cfg_we, no wait
//
// A start word walks every channel in ST_RUN and ends in ST_FIN; a tick word does
// the same, but a channel that has fallen a full period or more behind also goes
// through the bit-serial remainder unit shared by the channels (ST_DIV, ST_UPD).
// Reset clears all due times to zero and loads the default periods; no sweep.
// The response register lets the next request word be taken while a mask waits;
// the block holds in its final state only if a second mask is ready before then.
// Top level of the periodic due-time scheduler. Depends on pdts_pkg, the channel
// interfaces, pdts_ctrl, pdts_datapath and the assertion macro header.
`timescale 1ns / 1ps
`include "periodic_due_time_scheduler_macros.svh"

module periodic_due_time_scheduler (
	input  logic                            clk,
	input  logic                            arst_n,
	pdts_req_if.sink                        req,
	pdts_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [pdts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdts_pkg::PERIOD_W-1:0]   cfg_data
);
	import pdts_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       in_ready;

	assign req.ready = in_ready;

	pdts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (in_ready),
		.status    (status),
		.cmd       (cmd)
	);

	pdts_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_type  (req.req_type),
		.now_us    (req.now_us),
		.cmd       (cmd),
		.status    (status),
		.rsp       (rsp)
	);

	`PDTS_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "request taken while busy")
	`PDTS_ASSERT_NOW(a_push_has_slot, cmd.push, status.slot_free, "response register overwritten")
	`PDTS_ASSERT_NOW(a_commit_after_div, cmd.div_commit, $past(cmd.div_step) && $past(status.div_last), "remainder used before done")
	`PDTS_ASSERT_NEXT(a_start_no_fire, cmd.push && status.is_start, rsp.fire_mask == '0, "start word fired a channel")

endmodule

@@ src/pdts_ctrl.sv @@
// Sequencer of the scheduler: walks the channels and drives the datapath.
// Depends on pdts_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps

module pdts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  pdts_pkg::dp_status_t status,
	output pdts_pkg::dp_cmd_t    cmd
);
	import pdts_pkg::*;

	ctrl_state_t     state_q, state_d;
	logic [CH_W-1:0] ch_q, ch_d;
	logic            last_ch;
	logic            accept;

	assign last_ch = (ch_q == CH_W'(NUM_CHANNELS - 1));
	assign accept  = req_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
		end
	end

	// Next state and channel counter.
	always_comb begin
		state_d = state_q;
		ch_d    = ch_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_RUN;
					ch_d    = '0;
				end
			end
			ST_RUN: begin
				if (!status.is_start && status.fire && !status.fast) begin
					state_d = ST_DIV;
				end else if (last_ch) begin
					state_d = ST_FIN;
				end else begin
					ch_d = ch_q + 1'b1;
				end
			end
			ST_DIV: begin
				if (status.div_last) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (last_ch) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_RUN;
					ch_d    = ch_q + 1'b1;
				end
			end
			ST_FIN: begin
				if (status.slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd         = '0;
		cmd.ch      = ch_q;
		cmd.capture = accept;
		req_ready   = (state_q == ST_IDLE);
		case (state_q)
			ST_RUN: begin
				if (status.is_start) begin
					cmd.load_due = 1'b1;
				end else if (status.fire) begin
					cmd.step_due  = status.fast;
					cmd.div_start = !status.fast;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_UPD: begin
				cmd.div_commit = 1'b1;
			end
			ST_FIN: begin
				cmd.push = status.slot_free;
			end
			default: begin
				cmd.load_due = 1'b0;
			end
		endcase
	end

endmodule

@@ src/pdts_datapath.sv @@
// Datapath of the scheduler: period registers, due times, remainder unit and
// the response register. Depends on pdts_pkg and the response interface.
`timescale 1ns / 1ps

module pdts_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pdts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pdts_pkg::PERIOD_W-1:0]    cfg_data,
	input  logic                             req_type,
	input  logic [pdts_pkg::NOW_W-1:0]       now_us,
	input  pdts_pkg::dp_cmd_t                cmd,
	output pdts_pkg::dp_status_t             status,
	pdts_rsp_if.source                       rsp
);
	import pdts_pkg::*;

	logic [PERIOD_W-1:0] period_q [REG_COUNT];
	logic [NOW_W-1:0]    due_q    [NUM_CHANNELS];
	logic [NOW_W-1:0]    now_q;
	logic                type_q;
	logic [MASK_W-1:0]   mask_q;
	logic [MASK_W-1:0]   out_mask_q;
	logic                out_valid_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W-1:0] dsh_q;
	logic [DCNT_W-1:0]   dcnt_q;

	logic [PERIOD_W-1:0] per_raw;
	logic [PERIOD_W-1:0] per_eff;
	logic [NOW_W-1:0]    per_ext;
	logic [NOW_W-1:0]    due_cur;
	logic [NOW_W-1:0]    diff;
	logic [NOW_W-1:0]    trial;
	logic [NOW_W-1:0]    trial_sub;
	logic [PERIOD_W-1:0] rem_next;
	logic [REG_COUNT-1:0] mask_bit;

	// A period of zero behaves as a period of one.
	assign per_raw  = period_q[CFG_IDX_W'(cmd.ch)];
	assign per_eff  = (per_raw == '0) ? PERIOD_W'(1) : per_raw;
	assign per_ext  = {1'b0, per_eff};
	assign due_cur  = due_q[cmd.ch];
	assign diff     = now_q - due_cur;
	assign mask_bit = REG_COUNT'(1) << cmd.ch;

	// One restoring step of the remainder of diff by the period.
	assign trial     = {rem_q, dsh_q[PERIOD_W-1]};
	assign trial_sub = trial - per_ext;
	assign rem_next  = (trial >= per_ext) ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];

	assign status.is_start  = (type_q == REQ_START);
	assign status.fire      = !diff[NOW_W-1];
	assign status.fast      = (diff[PERIOD_W-1:0] < per_eff);
	assign status.div_last  = (dcnt_q == '0);
	assign status.slot_free = !out_valid_q || rsp.ready;

	assign rsp.valid     = out_valid_q;
	assign rsp.fire_mask = out_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				period_q[i] <= PERIOD_RST[i];
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
			period_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				due_q[i] <= '0;
			end
		end else if (cmd.load_due) begin
			due_q[cmd.ch] <= now_q + per_ext;
		end else if (cmd.step_due) begin
			due_q[cmd.ch] <= due_cur + per_ext;
		end else if (cmd.div_commit) begin
			// Skipping whole periods lands one period past now minus the remainder.
			due_q[cmd.ch] <= now_q - {1'b0, rem_q} + per_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q  <= now_us;
			type_q <= req_type;
		end
		if (cmd.div_start) begin
			rem_q  <= '0;
			dsh_q  <= diff[PERIOD_W-1:0];
			dcnt_q <= DCNT_W'(PERIOD_W - 1);
		end else if (cmd.div_step) begin
			rem_q  <= rem_next;
			dsh_q  <= {dsh_q[PERIOD_W-2:0], 1'b0};
			dcnt_q <= dcnt_q - 1'b1;
		end
		if (cmd.push) begin
			out_mask_q <= mask_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				mask_q <= '0;
			end else if (cmd.step_due || cmd.div_commit) begin
				mask_q <= mask_q | mask_bit;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
